// ===== hw/rtl/chunked_response_deframer_assert.svh =====
`ifndef CHUNKED_RESPONSE_DEFRAMER_ASSERT_SVH
`define CHUNKED_RESPONSE_DEFRAMER_ASSERT_SVH

// check a property on every clock edge outside reset
`define CRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every clock edge, reset included
`define CRD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/crd_pkg.sv =====
package crd_pkg;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_PAYLOAD = 2'd1;
  localparam logic [1:0] ST_DONE    = 2'd2;
  localparam logic [1:0] ST_ERROR   = 2'd3;

  localparam logic [3:0]  PREFIX_LEN = 4'd10;
  localparam logic [31:0] SAT32      = 32'hFFFF_FFFF;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  data_byte;
    logic [11:0] block_offset;
    logic        block_full;
    logic [31:0] total_bytes;
  } crd_result_t;

  function automatic logic [7:0] prefix_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = 8'h2B;
      4'd1:    c = 8'h48;
      4'd2:    c = 8'h54;
      4'd3:    c = 8'h54;
      4'd4:    c = 8'h50;
      4'd5:    c = 8'h43;
      4'd6:    c = 8'h47;
      4'd7:    c = 8'h45;
      4'd8:    c = 8'h54;
      4'd9:    c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/crd_core.sv =====
module crd_core
  import crd_pkg::*;
#(
  parameter int BLOCK_SIZE   = 4096,
  parameter int HEADER_LIMIT = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic        kind,
  input  logic [7:0]  byte_value,
  output logic        res_valid,
  output crd_result_t res
);

  localparam int BP_W = $clog2(BLOCK_SIZE);
  localparam int HL_W = $clog2(HEADER_LIMIT + 2);

  localparam logic [1:0] MODE_WAIT    = 2'd0;
  localparam logic [1:0] MODE_HEADER  = 2'd1;
  localparam logic [1:0] MODE_PAYLOAD = 2'd2;
  localparam logic [1:0] MODE_ENDED   = 2'd3;

  localparam logic [2:0] TOK_NONE = 3'd0;
  localparam logic [2:0] TOK_O    = 3'd1;
  localparam logic [2:0] TOK_E    = 3'd2;
  localparam logic [2:0] TOK_ER   = 3'd3;
  localparam logic [2:0] TOK_ERR  = 3'd4;
  localparam logic [2:0] TOK_ERRO = 3'd5;

  localparam logic [1:0] NUM_SKIP = 2'd0;
  localparam logic [1:0] NUM_DIG  = 2'd1;
  localparam logic [1:0] NUM_STOP = 2'd2;

  logic [1:0]      mode_r, mode_nxt;
  logic [2:0]      tok_r, tok_nxt;
  logic [HL_W-1:0] hlen_r, hlen_nxt;
  logic [3:0]      ppos_r, ppos_nxt;
  logic            pbrk_r, pbrk_nxt;
  logic [1:0]      nph_r, nph_nxt;
  logic [31:0]     csize_r, csize_nxt;
  logic [31:0]     ccnt_r, ccnt_nxt;
  logic [BP_W-1:0] bpos_r, bpos_nxt;
  logic [31:0]     total_r, total_nxt;

  logic        is_digit;
  logic        is_blank;
  logic [35:0] csize_x10;
  logic [BP_W+11:0] off_ext;

  assign is_digit  = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
  assign is_blank  = (byte_value == CH_SPACE) || ((byte_value >= CH_TAB) && (byte_value <= CH_CR));
  assign csize_x10 = ({4'b0, csize_r} << 3) + ({4'b0, csize_r} << 1)
                   + {32'b0, byte_value[3:0] - CH_ZERO[3:0]};
  assign off_ext   = {12'b0, bpos_r};

  always_comb begin
    mode_nxt  = mode_r;
    tok_nxt   = tok_r;
    hlen_nxt  = hlen_r;
    ppos_nxt  = ppos_r;
    pbrk_nxt  = pbrk_r;
    nph_nxt   = nph_r;
    csize_nxt = csize_r;
    ccnt_nxt  = ccnt_r;
    bpos_nxt  = bpos_r;
    total_nxt = total_r;
    res_valid = 1'b0;
    res.status       = ST_NONE;
    res.data_byte    = 8'd0;
    res.block_offset = 12'd0;
    res.block_full   = 1'b0;
    res.total_bytes  = total_r;

    if (kind) begin
      mode_nxt  = MODE_WAIT;
      tok_nxt   = TOK_NONE;
      hlen_nxt  = '0;
      ppos_nxt  = 4'd0;
      pbrk_nxt  = 1'b0;
      nph_nxt   = NUM_SKIP;
      csize_nxt = 32'd0;
      ccnt_nxt  = 32'd0;
      bpos_nxt  = '0;
      total_nxt = 32'd0;
    end else begin
      unique case (mode_r)
        MODE_WAIT: begin
          priority if (byte_value == CH_PLUS) begin
            mode_nxt  = MODE_HEADER;
            tok_nxt   = TOK_NONE;
            hlen_nxt  = HL_W'(1);
            ppos_nxt  = 4'd1;
            pbrk_nxt  = 1'b0;
            nph_nxt   = NUM_SKIP;
            csize_nxt = 32'd0;
          end else if (tok_r == TOK_ERR && byte_value == CH_O) begin
            tok_nxt = TOK_ERRO;
          end else if (tok_r == TOK_ERRO && byte_value == CH_R) begin
            mode_nxt   = MODE_ENDED;
            tok_nxt    = TOK_NONE;
            res_valid  = 1'b1;
            res.status = ST_ERROR;
          end else if (tok_r == TOK_O && byte_value == CH_K) begin
            mode_nxt   = MODE_ENDED;
            tok_nxt    = TOK_NONE;
            res_valid  = 1'b1;
            res.status = ST_DONE;
          end else if (byte_value == CH_O) begin
            tok_nxt = TOK_O;
          end else if (byte_value == CH_E) begin
            tok_nxt = TOK_E;
          end else if ((tok_r == TOK_E || tok_r == TOK_ER) && byte_value == CH_R) begin
            tok_nxt = tok_r + 3'd1;
          end else begin
            tok_nxt = TOK_NONE;
          end
        end
        MODE_HEADER: begin
          hlen_nxt = hlen_r + HL_W'(1);
          priority if (!pbrk_r && ppos_r >= PREFIX_LEN) begin
            if (byte_value == CH_COMMA) begin
              ccnt_nxt = 32'd0;
              mode_nxt = (csize_r != 32'd0) ? MODE_PAYLOAD : MODE_WAIT;
            end else if (nph_r == NUM_SKIP && is_blank) begin
              nph_nxt = nph_r;
            end else if (nph_r != NUM_STOP && is_digit) begin
              csize_nxt = (csize_x10[35:32] != 4'd0) ? SAT32 : csize_x10[31:0];
              nph_nxt   = NUM_DIG;
            end else begin
              nph_nxt = NUM_STOP;
            end
          end else if (!pbrk_r && byte_value == prefix_char(ppos_r)) begin
            ppos_nxt = ppos_r + 4'd1;
          end else begin
            pbrk_nxt = 1'b1;
          end
          if (hlen_nxt > HL_W'(HEADER_LIMIT)) begin
            mode_nxt = MODE_WAIT;
          end
        end
        MODE_PAYLOAD: begin
          ccnt_nxt  = ccnt_r + 32'd1;
          total_nxt = (total_r != SAT32) ? total_r + 32'd1 : total_r;
          if (ccnt_nxt >= csize_r) begin
            mode_nxt = MODE_WAIT;
            tok_nxt  = TOK_NONE;
          end
          res_valid        = 1'b1;
          res.status       = ST_PAYLOAD;
          res.data_byte    = byte_value;
          res.block_offset = off_ext[11:0];
          res.total_bytes  = total_nxt;
          if (bpos_r == BP_W'(BLOCK_SIZE - 1)) begin
            res.block_full = 1'b1;
            bpos_nxt       = '0;
          end else begin
            bpos_nxt = bpos_r + BP_W'(1);
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_WAIT;
      tok_r   <= TOK_NONE;
      hlen_r  <= '0;
      ppos_r  <= 4'd0;
      pbrk_r  <= 1'b0;
      nph_r   <= NUM_SKIP;
      csize_r <= 32'd0;
      ccnt_r  <= 32'd0;
      bpos_r  <= '0;
      total_r <= 32'd0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      tok_r   <= tok_nxt;
      hlen_r  <= hlen_nxt;
      ppos_r  <= ppos_nxt;
      pbrk_r  <= pbrk_nxt;
      nph_r   <= nph_nxt;
      csize_r <= csize_nxt;
      ccnt_r  <= ccnt_nxt;
      bpos_r  <= bpos_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

// ===== hw/rtl/chunked_response_deframer.sv =====
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  in_kind, in_byte_value
// out      output     out_valid/out_stall out_status, out_data_byte, out_block_offset,
//                                         out_block_full, out_total_bytes
//
// A byte is accepted per cycle while in_stall is low; any result is registered.
// Parser state updates in the cycle of acceptance, so the rate is set by nothing
// but the two-entry result queue (output register plus skid register).
// in_stall rises only while the skid register holds a result.
// Synchronous active-low reset clears parser state and empties the queue.
module chunked_response_deframer
  import crd_pkg::*;
#(
  parameter int BLOCK_SIZE   = 4096,
  parameter int HEADER_LIMIT = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_data_byte,
  output logic [11:0] out_block_offset,
  output logic        out_block_full,
  output logic [31:0] out_total_bytes
);

`include "chunked_response_deframer_assert.svh"

  logic        accept;
  logic        pop;
  logic        push;
  logic        res_valid;
  crd_result_t res;

  logic        main_valid_r, main_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  crd_result_t main_r, main_nxt;
  crd_result_t skid_r, skid_nxt;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign push     = accept && res_valid;
  assign pop      = main_valid_r && !out_stall;

  crd_core #(
    .BLOCK_SIZE   (BLOCK_SIZE),
    .HEADER_LIMIT (HEADER_LIMIT)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .kind       (in_kind),
    .byte_value (in_byte_value),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    priority if (!main_valid_r || (pop && !skid_valid_r)) begin
      main_valid_nxt = push;
      main_nxt       = res;
    end else if (pop) begin
      main_valid_nxt = 1'b1;
      main_nxt       = skid_r;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = main_valid_r;
  assign out_status       = main_r.status;
  assign out_data_byte    = main_r.data_byte;
  assign out_block_offset = main_r.block_offset;
  assign out_block_full   = main_r.block_full;
  assign out_total_bytes  = main_r.total_bytes;

  `CRD_ASSERT_ALWAYS(a_skid_behind_main, skid_valid_r |-> main_valid_r, "skid holds without output")
  `CRD_ASSERT(a_skid_fill_on_stall, $rose(skid_valid_r) |-> $past(out_stall), "skid filled without stall")
  `CRD_ASSERT(a_no_empty_result, main_valid_r |-> (main_r.status != ST_NONE), "empty result shown")
  `CRD_ASSERT(a_full_is_payload, (main_valid_r && main_r.block_full) |-> (main_r.status == ST_PAYLOAD), "block full on non-payload")

endmodule
